// ===== rtl/core/mwg_pkg.sv =====
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared types, code tables and lookup helpers for the weather group parser.
// ----------------------------------------------------------------------------
package mwg_pkg;

    localparam int CountSat = 4;

    // Result codes that are set directly rather than looked up.
    localparam logic [1:0] INT_LIGHT     = 2'd1;
    localparam logic [1:0] INT_HEAVY     = 2'd2;
    localparam logic [1:0] INT_VICINITY  = 2'd3;
    localparam logic [3:0] DESC_NONE     = 4'd0;
    localparam logic [3:0] DESC_NSW      = 4'd9;
    localparam logic [3:0] PREC_NONE     = 4'd0;
    localparam logic [3:0] OBSC_NONE     = 4'd0;
    localparam logic [2:0] MISC_NONE     = 3'd0;
    localparam logic [1:0] INT_MODERATE  = 2'd0;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [15:0] PAIR_VC   = "VC";

    localparam logic [7:0] NSW_WORD [3] = '{"N", "S", "W"};

    localparam logic [15:0] DESC_TAB [8] = '{"MI", "PR", "BC", "DR", "BL", "SH", "TS", "FZ"};
    localparam logic [15:0] PREC_TAB [9] =
        '{"DZ", "RA", "SN", "SG", "IC", "PE", "GR", "GS", "UP"};
    localparam logic [15:0] OBSC_TAB [8] = '{"BR", "FG", "FU", "VA", "DU", "SA", "HZ", "PY"};
    localparam logic [15:0] MISC_TAB [5] = '{"PO", "SQ", "FC", "SS", "DS"};

    // Parse phases in the order the group is scanned.
    typedef enum logic [3:0] {
        PH_INT0,
        PH_INT1,
        PH_DESC0,
        PH_PREC0,
        PH_PREC_MORE,
        PH_DESC1,
        PH_OBSC,
        PH_MISC,
        PH_INT2,
        PH_DONE
    } phase_t;

    // Classified character, passed from the front end to the parser.
    typedef struct packed {
        logic       last;
        logic       short_grp;
        logic       nsw_hit;
        logic       cur_plus;
        logic       cur_minus;
        logic       vc;
        logic [3:0] desc;
        logic [3:0] prec;
        logic [3:0] obsc;
        logic [2:0] misc;
    } tok_t;

    function automatic logic [3:0] desc_code(logic [15:0] pair);
        logic [3:0] code;
        code = DESC_NONE;
        for (int i = 0; i < 8; i++) begin
            if (pair == DESC_TAB[i]) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic logic [3:0] prec_code(logic [15:0] pair);
        logic [3:0] code;
        code = PREC_NONE;
        for (int i = 0; i < 9; i++) begin
            if (pair == PREC_TAB[i]) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic logic [3:0] obsc_code(logic [15:0] pair);
        logic [3:0] code;
        code = OBSC_NONE;
        for (int i = 0; i < 8; i++) begin
            if (pair == OBSC_TAB[i]) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic logic [2:0] misc_code(logic [15:0] pair);
        logic [2:0] code;
        code = MISC_NONE;
        for (int i = 0; i < 5; i++) begin
            if (pair == MISC_TAB[i]) begin
                code = 3'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/mwg_front.sv =====
// ----------------------------------------------------------------------------
// mwg_front
// Accepts characters, tracks group length and the NSW word, and classifies
// each character together with its predecessor into two-letter codes.
// ----------------------------------------------------------------------------
module mwg_front
    import mwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic       q_full,
    output logic       push,
    output tok_t       push_tok
);

    logic [7:0]  prev_char_reg;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        nsw_ok_reg;
    logic        nsw_ok_next;
    logic [15:0] pair;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign pair     = {prev_char_reg, char_code};

    always_comb
    begin
        count_next  = (count_reg < 3'(CountSat)) ? count_reg + 3'd1 : count_reg;
        nsw_ok_next = 1'b0;
        if (count_reg < 3'd3)
        begin
            nsw_ok_next = nsw_ok_reg && (char_code == NSW_WORD[count_reg[1:0]]);
        end

        push_tok.last      = last_char;
        push_tok.short_grp = (count_next < 3'd2);
        push_tok.nsw_hit   = (count_next == 3'd3) && nsw_ok_next;
        push_tok.cur_plus  = (char_code == CHAR_PLUS);
        push_tok.cur_minus = (char_code == CHAR_MINUS);
        // The pair codes are only meaningful when a character is held, which the
        // parser knows; on the first character of a group they are ignored.
        push_tok.vc        = (pair == PAIR_VC);
        push_tok.desc      = desc_code(pair);
        push_tok.prec      = prec_code(pair);
        push_tok.obsc      = obsc_code(pair);
        push_tok.misc      = misc_code(pair);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 3'd0;
            nsw_ok_reg <= 1'b1;
        end
        else if (push)
        begin
            if (last_char)
            begin
                count_reg  <= 3'd0;
                nsw_ok_reg <= 1'b1;
            end
            else
            begin
                count_reg  <= count_next;
                nsw_ok_reg <= nsw_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            prev_char_reg <= char_code;
        end
    end

endmodule

// ===== rtl/core/mwg_queue.sv =====
// ----------------------------------------------------------------------------
// mwg_queue
// Two-entry queue of classified characters between front end and parser.
// ----------------------------------------------------------------------------
module mwg_queue
    import mwg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t push_tok,
    output logic full,
    output logic q_valid,
    output tok_t q_tok,
    input  logic pop
);

    tok_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_tok   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ===== rtl/core/mwg_back.sv =====
// ----------------------------------------------------------------------------
// mwg_back
// Phase-ordered parser: walks the held character through the remaining
// phases, updates the stored codes and registers one result per group.
// ----------------------------------------------------------------------------
module mwg_back
    import mwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  tok_t       q_tok,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       group_ok,
    output logic [1:0] out_intensity,
    output logic [3:0] out_descriptor,
    output logic [3:0] out_precip,
    output logic [3:0] out_obscuration,
    output logic [2:0] out_misc
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    logic       held_plus_reg;
    logic       held_plus_next;
    logic       held_minus_reg;
    logic       held_minus_next;
    logic       failed_reg;
    logic       failed_next;
    logic [1:0] int_reg;
    logic [1:0] int_next;
    logic [3:0] desc_reg;
    logic [3:0] desc_next;
    logic [3:0] prec_reg;
    logic [3:0] prec_next;
    logic [3:0] obsc_reg;
    logic [3:0] obsc_next;
    logic [2:0] misc_reg;
    logic [2:0] misc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       ok_reg;
    logic [1:0] res_int_reg;
    logic [3:0] res_desc_reg;
    logic [3:0] res_prec_reg;
    logic [3:0] res_obsc_reg;
    logic [2:0] res_misc_reg;
    logic       ok;
    logic       held_sign;
    logic [1:0] held_int;
    logic       take_one;
    logic       int_phase;

    // A non-final character never touches the result register, so it may go
    // through even while a result waits to be taken.
    assign pop       = q_valid && !(q_tok.last && out_valid_reg && out_stall);
    assign held_sign = held_plus_reg || held_minus_reg;
    assign held_int  = held_plus_reg ? INT_HEAVY : INT_LIGHT;

    assign out_valid       = out_valid_reg;
    assign group_ok        = ok_reg;
    assign out_intensity   = res_int_reg;
    assign out_descriptor  = res_desc_reg;
    assign out_precip      = res_prec_reg;
    assign out_obscuration = res_obsc_reg;
    assign out_misc        = res_misc_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        held_valid_next = held_valid_reg;
        held_plus_next  = held_plus_reg;
        held_minus_next = held_minus_reg;
        failed_next     = failed_reg;
        int_next        = int_reg;
        desc_next       = desc_reg;
        prec_next       = prec_reg;
        obsc_next       = obsc_reg;
        misc_next       = misc_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ok              = 1'b0;
        take_one        = 1'b0;
        int_phase       = 1'b0;

        if (pop && !failed_reg)
        begin
            if (held_valid_reg)
            begin
                // First phase at or after the current one that takes the held
                // character, or the held character with this one as a pair.
                case (1'b1)
                    (phase_reg <= PH_INT1) && held_sign:
                    begin
                        int_next   = held_int;
                        phase_next = (phase_reg == PH_INT0) ? PH_INT1 : PH_DESC0;
                        take_one   = 1'b1;
                    end
                    (phase_reg <= PH_INT1) && q_tok.vc:
                    begin
                        int_next   = INT_VICINITY;
                        phase_next = (phase_reg == PH_INT0) ? PH_INT1 : PH_DESC0;
                    end
                    (phase_reg <= PH_DESC0) && (q_tok.desc != DESC_NONE):
                    begin
                        desc_next  = q_tok.desc;
                        phase_next = PH_PREC0;
                    end
                    (phase_reg <= PH_PREC0) && (q_tok.prec != PREC_NONE):
                    begin
                        prec_next  = q_tok.prec;
                        phase_next = PH_PREC_MORE;
                    end
                    (phase_reg == PH_PREC_MORE) && (q_tok.prec != PREC_NONE):
                    begin
                        phase_next = PH_PREC_MORE;
                    end
                    (phase_reg <= PH_DESC1) && (q_tok.desc != DESC_NONE):
                    begin
                        desc_next  = q_tok.desc;
                        phase_next = PH_OBSC;
                    end
                    (phase_reg <= PH_OBSC) && (q_tok.obsc != OBSC_NONE):
                    begin
                        obsc_next  = q_tok.obsc;
                        phase_next = PH_MISC;
                    end
                    (phase_reg <= PH_MISC) && (q_tok.misc != MISC_NONE):
                    begin
                        misc_next  = q_tok.misc;
                        phase_next = PH_INT2;
                    end
                    (phase_reg <= PH_INT2) && held_sign:
                    begin
                        int_next   = held_int;
                        phase_next = PH_DONE;
                        take_one   = 1'b1;
                    end
                    (phase_reg <= PH_INT2) && q_tok.vc:
                    begin
                        int_next   = INT_VICINITY;
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next  = PH_DONE;
                        failed_next = 1'b1;
                    end
                endcase

                if (take_one)
                begin
                    held_plus_next  = q_tok.cur_plus;
                    held_minus_next = q_tok.cur_minus;
                end
                else
                begin
                    held_valid_next = 1'b0;
                end
            end
            else
            begin
                held_valid_next = 1'b1;
                held_plus_next  = q_tok.cur_plus;
                held_minus_next = q_tok.cur_minus;
            end
        end

        if (pop && q_tok.last)
        begin
            if (!q_tok.short_grp)
            begin
                // With no character after it, the held one can only be a sign,
                // and the closing intensity phase takes it from any unfinished
                // phase.
                int_phase = (phase_next != PH_DONE);
                ok = !failed_next;
                if (held_valid_next && !failed_next)
                begin
                    if (int_phase && (held_plus_next || held_minus_next))
                    begin
                        int_next = held_plus_next ? INT_HEAVY : INT_LIGHT;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                if (q_tok.nsw_hit)
                begin
                    desc_next = DESC_NSW;
                    ok        = 1'b1;
                end
            end
            out_valid_next  = 1'b1;
            phase_next      = PH_INT0;
            held_valid_next = 1'b0;
            held_plus_next  = 1'b0;
            held_minus_next = 1'b0;
            failed_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_INT0;
            held_valid_reg <= 1'b0;
            held_plus_reg  <= 1'b0;
            held_minus_reg <= 1'b0;
            failed_reg     <= 1'b0;
            int_reg        <= INT_MODERATE;
            desc_reg       <= DESC_NONE;
            prec_reg       <= PREC_NONE;
            obsc_reg       <= OBSC_NONE;
            misc_reg       <= MISC_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_valid_reg <= held_valid_next;
            held_plus_reg  <= held_plus_next;
            held_minus_reg <= held_minus_next;
            failed_reg     <= failed_next;
            int_reg        <= int_next;
            desc_reg       <= desc_next;
            prec_reg       <= prec_next;
            obsc_reg       <= obsc_next;
            misc_reg       <= misc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_tok.last)
        begin
            ok_reg       <= ok;
            res_int_reg  <= int_next;
            res_desc_reg <= desc_next;
            res_prec_reg <= prec_next;
            res_obsc_reg <= obsc_next;
            res_misc_reg <= misc_next;
        end
    end

endmodule

// ===== rtl/core/metar_weather_group_parser.sv =====
// ----------------------------------------------------------------------------
// metar_weather_group_parser
// Present-weather group parser, one character per transfer.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ---------------------------------------
//   input     in_valid / in_stall   char_code, last_char
//   output    out_valid / out_stall group_ok, out_intensity, out_descriptor,
//                                   out_precip, out_obscuration, out_misc
//
// One character is taken every cycle while the queue is not full. A result is
// presented once the character that ends its group has passed through the
// queue and the parser has registered the result as that character leaves.
// The parse loop is a combinational scan over the remaining phases, so the
// rate is one character per cycle while no group end waits on a stalled result.
// Reset clears the stored codes to none/moderate and starts a fresh group.
// A stalled result only holds back the next group-ending character; other
// characters keep flowing until the two-entry queue fills.
// ----------------------------------------------------------------------------
module metar_weather_group_parser
    import mwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       group_ok,
    output logic [1:0] out_intensity,
    output logic [3:0] out_descriptor,
    output logic [3:0] out_precip,
    output logic [3:0] out_obscuration,
    output logic [2:0] out_misc
);

    logic q_full;
    logic push;
    tok_t push_tok;
    logic q_valid;
    tok_t q_tok;
    logic pop;

    mwg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .q_full    (q_full),
        .push      (push),
        .push_tok  (push_tok)
    );

    mwg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_tok    (q_tok),
        .pop      (pop)
    );

    mwg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_tok           (q_tok),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .group_ok        (group_ok),
        .out_intensity   (out_intensity),
        .out_descriptor  (out_descriptor),
        .out_precip      (out_precip),
        .out_obscuration (out_obscuration),
        .out_misc        (out_misc)
    );

endmodule

// ===== dv/weather_group_checker.sv =====
// ----------------------------------------------------------------------------
// weather_group_checker
// Watches both channels of the weather group parser, predicts each group
// report from the accepted characters and compares every report it sees.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module weather_group_checker
    import mwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       group_ok,
    input  logic [1:0] out_intensity,
    input  logic [3:0] out_descriptor,
    input  logic [3:0] out_precip,
    input  logic [3:0] out_obscuration,
    input  logic [2:0] out_misc,
    output int         fail_count,
    output int         pending,
    output int         reports_seen,
    output int         clean_seen
);

    typedef struct packed {
        logic       ok;
        logic [1:0] intensity;
        logic [3:0] descriptor;
        logic [3:0] precip;
        logic [3:0] obscuration;
        logic [2:0] misc;
    } weather_report_t;

    weather_report_t expected_reports[$];

    // Stored codes, kept across groups.
    logic [1:0] cur_intensity;
    logic [3:0] cur_descriptor;
    logic [3:0] cur_precip;
    logic [3:0] cur_obscuration;
    logic [2:0] cur_misc;

    // Per-group scan state.
    phase_t     scan_phase;
    logic [7:0] held_byte;
    logic       held_ok;
    logic       group_failed;
    logic [2:0] char_total;
    logic       nsw_match;

    function automatic int pair_index(string tab, logic [7:0] a, logic [7:0] b);
        for (int i = 0; i < tab.len() / 2; i++) begin
            if (tab[2 * i] == a && tab[2 * i + 1] == b) begin
                return i + 1;
            end
        end
        return 0;
    endfunction

    // Runs the phases from the current one at the held character; returns how
    // many characters were consumed, or 0 when no remaining phase can take it.
    function automatic int scan_phases(logic [7:0] h, logic has_next, logic [7:0] n);
        int code;
        while (scan_phase != PH_DONE) begin
            code = 0;
            case (scan_phase)
                PH_INT0, PH_INT1, PH_INT2:
                begin
                    scan_phase = phase_t'(scan_phase + 1);
                    if (h == CHAR_PLUS) begin
                        cur_intensity = INT_HEAVY;
                        return 1;
                    end
                    if (h == CHAR_MINUS) begin
                        cur_intensity = INT_LIGHT;
                        return 1;
                    end
                    if (has_next && {h, n} == PAIR_VC) begin
                        cur_intensity = INT_VICINITY;
                        return 2;
                    end
                end
                PH_DESC0, PH_DESC1:
                begin
                    if (has_next) code = pair_index("MIPRBCDRBLSHTSFZ", h, n);
                    scan_phase = phase_t'(scan_phase + 1);
                    if (code != 0) begin
                        cur_descriptor = 4'(code);
                        return 2;
                    end
                end
                PH_PREC0:
                begin
                    if (has_next) code = pair_index("DZRASNSGICPEGRGSUP", h, n);
                    if (code != 0) begin
                        cur_precip = 4'(code);
                        scan_phase = PH_PREC_MORE;
                        return 2;
                    end
                    scan_phase = PH_DESC1;
                end
                PH_PREC_MORE:
                begin
                    // Further precipitation is swallowed without being stored.
                    if (has_next) code = pair_index("DZRASNSGICPEGRGSUP", h, n);
                    if (code != 0) return 2;
                    scan_phase = PH_DESC1;
                end
                PH_OBSC:
                begin
                    if (has_next) code = pair_index("BRFGFUVADUSAHZPY", h, n);
                    scan_phase = phase_t'(scan_phase + 1);
                    if (code != 0) begin
                        cur_obscuration = 4'(code);
                        return 2;
                    end
                end
                default:
                begin
                    if (has_next) code = pair_index("POSQFCSSDS", h, n);
                    scan_phase = phase_t'(scan_phase + 1);
                    if (code != 0) begin
                        cur_misc = 3'(code);
                        return 2;
                    end
                end
            endcase
        end
        group_failed = 1'b1;
        return 0;
    endfunction

    task automatic clear_group();
        scan_phase   = PH_INT0;
        held_byte    = 8'h00;
        held_ok      = 1'b0;
        group_failed = 1'b0;
        char_total   = 3'd0;
        nsw_match    = 1'b1;
    endtask

    task automatic take_char(logic [7:0] c, logic last);
        logic [7:0]      nsw_char;
        int              used;
        weather_report_t rep;
        if (char_total < 3) begin
            case (char_total)
                3'd0:    nsw_char = "N";
                3'd1:    nsw_char = "S";
                default: nsw_char = "W";
            endcase
            nsw_match = nsw_match && (c == nsw_char);
        end else begin
            nsw_match = 1'b0;
        end
        if (char_total < CountSat) char_total++;

        if (!group_failed) begin
            if (held_ok) begin
                used = scan_phases(held_byte, 1'b1, c);
                if (used == 1) begin
                    held_byte = c;
                end else begin
                    held_ok   = 1'b0;
                    held_byte = 8'h00;
                end
            end else begin
                held_byte = c;
                held_ok   = 1'b1;
            end
        end

        if (last) begin
            rep.ok = 1'b0;
            // A one-character group is never parsed at all.
            if (char_total >= 2) begin
                if (held_ok && !group_failed) used = scan_phases(held_byte, 1'b0, 8'h00);
                rep.ok = !group_failed;
                if (char_total == 3 && nsw_match) begin
                    cur_descriptor = DESC_NSW;
                    rep.ok = 1'b1;
                end
            end
            rep.intensity   = cur_intensity;
            rep.descriptor  = cur_descriptor;
            rep.precip      = cur_precip;
            rep.obscuration = cur_obscuration;
            rep.misc        = cur_misc;
            expected_reports.push_back(rep);
            clear_group();
        end
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_report();
        weather_report_t want;
        if (expected_reports.size() == 0) begin
            $display("%0t: report with no group pending, expected none, actual ok=%0d",
                     $time, group_ok);
            fail_count++;
        end else begin
            want = expected_reports.pop_front();
            reports_seen++;
            if (want.ok) clean_seen++;
            compare_field("group_ok", want.ok, group_ok);
            compare_field("out_intensity", want.intensity, out_intensity);
            compare_field("out_descriptor", want.descriptor, out_descriptor);
            compare_field("out_precip", want.precip, out_precip);
            compare_field("out_obscuration", want.obscuration, out_obscuration);
            compare_field("out_misc", want.misc, out_misc);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            cur_intensity   = INT_MODERATE;
            cur_descriptor  = DESC_NONE;
            cur_precip      = PREC_NONE;
            cur_obscuration = OBSC_NONE;
            cur_misc        = MISC_NONE;
            clear_group();
            expected_reports.delete();
            fail_count   = 0;
            reports_seen = 0;
            clean_seen   = 0;
        end else begin
            if (out_valid && !out_stall) check_report();
            if (in_valid && !in_stall) take_char(char_code, last_char);
        end
        pending = expected_reports.size();
    end

endmodule

// ===== dv/metar_weather_group_parser_tb.sv =====
// ----------------------------------------------------------------------------
// metar_weather_group_parser_tb
// Feeds directed and random weather groups to the parser one character per
// transfer, with random gaps and output stalls, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module metar_weather_group_parser_tb;
    import mwg_pkg::*;

    localparam int RandomChars    = 500;
    localparam int HoldCycles     = 200;
    localparam int PressureGroups = 40;
    localparam int DrainCycles    = 20;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       last_char = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       group_ok;
    logic [1:0] out_intensity;
    logic [3:0] out_descriptor;
    logic [3:0] out_precip;
    logic [3:0] out_obscuration;
    logic [2:0] out_misc;

    bit  calm     = 1'b0;
    bit  hold_req = 1'b0;
    int  chars_sent  = 0;
    int  groups_sent = 0;
    int  fail_count;
    int  pending;
    int  reports_seen;
    int  clean_seen;
    logic [7:0] group_chars[$];

    always #5 clk = ~clk;

    metar_weather_group_parser DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .group_ok       (group_ok),
        .out_intensity  (out_intensity),
        .out_descriptor (out_descriptor),
        .out_precip     (out_precip),
        .out_obscuration(out_obscuration),
        .out_misc       (out_misc)
    );

    weather_group_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .group_ok       (group_ok),
        .out_intensity  (out_intensity),
        .out_descriptor (out_descriptor),
        .out_precip     (out_precip),
        .out_obscuration(out_obscuration),
        .out_misc       (out_misc),
        .fail_count     (fail_count),
        .pending        (pending),
        .reports_seen   (reports_seen),
        .clean_seen     (clean_seen)
    );

    // Mostly short idle runs, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Entered and left at a falling edge; valid is dropped after the transfer.
    task automatic push_char(logic [7:0] c, logic last);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = c;
        last_char = last;
        do @(posedge clk); while (in_stall);
        chars_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_group();
        for (int i = 0; i < group_chars.size(); i++) begin
            push_char(group_chars[i], i == group_chars.size() - 1);
        end
        groups_sent++;
    endtask

    task automatic load_text(string s);
        group_chars.delete();
        for (int i = 0; i < s.len(); i++) group_chars.push_back(s[i]);
    endtask

    task automatic add_pair(logic [15:0] p);
        group_chars.push_back(p[15:8]);
        group_chars.push_back(p[7:0]);
    endtask

    // Mostly well-formed groups with random content; the rest are exact NSW,
    // corrupted, truncated or plain random bytes.
    task automatic compose_group();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            load_text("NSW");
            return;
        end
        group_chars.delete();
        case ($urandom_range(0, 3))
            1:       group_chars.push_back(CHAR_PLUS);
            2:       group_chars.push_back(CHAR_MINUS);
            3:       add_pair(PAIR_VC);
            default: ;
        endcase
        if ($urandom_range(0, 99) < 40) add_pair(DESC_TAB[3'($urandom_range(0, 7))]);
        repeat ($urandom_range(0, 3)) add_pair(PREC_TAB[4'($urandom_range(0, 8))]);
        if ($urandom_range(0, 99) < 15) add_pair(DESC_TAB[3'($urandom_range(0, 7))]);
        if ($urandom_range(0, 99) < 40) add_pair(OBSC_TAB[3'($urandom_range(0, 7))]);
        if ($urandom_range(0, 99) < 25) add_pair(MISC_TAB[3'($urandom_range(0, 4))]);
        if ($urandom_range(0, 99) < 15) begin
            group_chars.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        end
        if (group_chars.size() == 0) add_pair(PREC_TAB[4'($urandom_range(0, 8))]);

        if (r < 18) begin
            group_chars[$urandom_range(0, group_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 24) begin
            group_chars = group_chars[0 : $urandom_range(0, group_chars.size() - 1)];
        end else if (r < 30) begin
            group_chars.delete();
            repeat ($urandom_range(1, 5)) group_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Output side: random stalls, plus one long hold when asked for.
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (HoldCycles - 1) @(negedge clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 99) < 70) begin
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b1;
                repeat (idle_length() - 1) @(negedge clk);
            end
        end
    end

    initial begin
        int  base;
        int  calm_left;
        bit  pressed;
        calm_left = 0;
        pressed   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        load_text("NSW");
        send_group();
        group_chars = '{8'h00};
        send_group();
        load_text("+SHRASN");
        send_group();
        load_text("VCFGPO");
        send_group();
        group_chars = '{CHAR_MINUS, 8'hFF, "Z"};
        send_group();
        load_text("UPBR-");
        send_group();
        while (pending != 0) @(negedge clk);

        base = chars_sent;
        while (chars_sent < base + RandomChars) begin
            if (!pressed && chars_sent > base + RandomChars / 2) begin
                // Back-to-back groups against a held-off output, enough that the
                // input stalls, then let everything drain.
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (PressureGroups) begin
                    compose_group();
                    send_group();
                end
                calm = 1'b0;
                while (pending != 0) @(negedge clk);
                pressed = 1'b1;
            end
            if (calm_left > 0) begin
                calm_left--;
            end else begin
                calm      = ($urandom_range(0, 5) == 0);
                calm_left = $urandom_range(2, 6);
            end
            compose_group();
            send_group();
        end
        in_valid = 1'b0;
        calm     = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        $display("Sent %0d characters in %0d groups; checked %0d reports, %0d of them clean.",
                 chars_sent, groups_sent, reports_seen, clean_seen);
        if (fail_count == 0) begin
            $display("metar_weather_group_parser verification clean");
        end else begin
            $display("metar_weather_group_parser verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d reports outstanding", $time, pending);
        $display("metar_weather_group_parser verification failed");
        $finish;
    end

endmodule
